@@ hw/rtl/rrb_pkg.sv @@
// Shared widths, register indexes and helper functions for the rotated rectangle bounds block.
`timescale 1ns / 1ps

package rrb_pkg;

  localparam int COORD_BITS  = 16;
  localparam int FRAC_BITS   = 14;
  localparam int FACTOR_BITS = FRAC_BITS + 2;

  // Coordinate minus origin, product of a difference and a factor, and the wide sum.
  localparam int DIFF_BITS = COORD_BITS + 1;
  localparam int PROD_BITS = DIFF_BITS + FACTOR_BITS;
  localparam int SUM_BITS  = PROD_BITS + 2;
  localparam int INT_BITS  = SUM_BITS - FRAC_BITS;

  localparam int FIELD_BITS = 4 * COORD_BITS;
  localparam int DATA_BITS  = ((FIELD_BITS + 7) / 8) * 8;

  localparam int CFG_IDX_BITS  = 8;
  localparam int CFG_DATA_BITS = (FACTOR_BITS > COORD_BITS) ? FACTOR_BITS : COORD_BITS;

  localparam logic [CFG_IDX_BITS-1:0] CFG_COS_FACTOR = CFG_IDX_BITS'(0);
  localparam logic [CFG_IDX_BITS-1:0] CFG_SIN_FACTOR = CFG_IDX_BITS'(1);
  localparam logic [CFG_IDX_BITS-1:0] CFG_ORIGIN_X   = CFG_IDX_BITS'(2);
  localparam logic [CFG_IDX_BITS-1:0] CFG_ORIGIN_Y   = CFG_IDX_BITS'(3);

  localparam logic signed [FACTOR_BITS-1:0] FACTOR_ONE =
    {{(FACTOR_BITS - FRAC_BITS - 1){1'b0}}, 1'b1, {FRAC_BITS{1'b0}}};

  localparam logic signed [SUM_BITS-1:0] CEIL_BIAS =
    {{(SUM_BITS - FRAC_BITS){1'b0}}, {FRAC_BITS{1'b1}}};

  localparam logic signed [COORD_BITS-1:0] COORD_MAX = {1'b0, {(COORD_BITS - 1){1'b1}}};
  localparam logic signed [COORD_BITS-1:0] COORD_MIN = {1'b1, {(COORD_BITS - 1){1'b0}}};

  typedef logic signed [COORD_BITS-1:0] coord_t;
  typedef logic signed [DIFF_BITS-1:0]  diff_t;
  typedef logic signed [PROD_BITS-1:0]  prod_t;
  typedef logic signed [SUM_BITS-1:0]   sum_t;
  typedef logic signed [INT_BITS-1:0]   int_part_t;

  function automatic coord_t sat_coord(input int_part_t v);
    logic fits;
    begin
      fits = (&v[INT_BITS-1:COORD_BITS-1]) | ~(|v[INT_BITS-1:COORD_BITS-1]);
      if (fits) begin
        sat_coord = v[COORD_BITS-1:0];
      end else if (v[INT_BITS-1]) begin
        sat_coord = COORD_MIN;
      end else begin
        sat_coord = COORD_MAX;
      end
    end
  endfunction

  function automatic prod_t min_prod(input prod_t a, input prod_t b);
    min_prod = (a < b) ? a : b;
  endfunction

  function automatic prod_t max_prod(input prod_t a, input prod_t b);
    max_prod = (a > b) ? a : b;
  endfunction

endpackage

@@ hw/rtl/rotated_rect_bounds_core.sv @@
// Top level of the rotated rectangle bounds block: a five-stage pipeline.
`timescale 1ns / 1ps

// Each input beat carries one rectangle (left, top, right, bottom) and a last flag; the block
// rotates its four corners about the configured origin with the Q1.14 cosine and sine and
// returns the integer bounding box (floor of the minimum, ceiling of the maximum), saturated
// to the signed coordinate range, with the last flag copied across. One rectangle is accepted
// every cycle while the output is not stalled; it passes through the five register stages
// (origin subtraction, products, extremes, sums, rounding and saturation). Every stage holds
// its own beat, so gaps close up and input is still taken while a result waits at the output,
// as long as some stage is empty. Configuration writes are always accepted and should be made
// only while the pipeline is empty.
module rotated_rect_bounds_core (
  input  logic                                clk,
  input  logic                                rst_n,
  // Configuration write channel.
  input  logic                                cfg_valid,
  output logic                                cfg_ready,
  input  logic [rrb_pkg::CFG_IDX_BITS-1:0]    cfg_index,
  input  logic [rrb_pkg::CFG_DATA_BITS-1:0]   cfg_data,
  // Input stream.
  input  logic                                in_tvalid,
  output logic                                in_tready,
  input  logic [rrb_pkg::DATA_BITS-1:0]       in_tdata,  // left, top, right, bottom
  input  logic                                in_tlast,  // last_in
  // Result stream.
  output logic                                out_tvalid,
  input  logic                                out_tready,
  output logic [rrb_pkg::DATA_BITS-1:0]       out_tdata, // bound_left, bound_top,
                                                         // bound_right, bound_bottom
  output logic                                out_tlast  // last_out
);

  localparam int CB = rrb_pkg::COORD_BITS;

  logic signed [rrb_pkg::FACTOR_BITS-1:0] cos_r;
  logic signed [rrb_pkg::FACTOR_BITS-1:0] sin_r;
  rrb_pkg::coord_t                        org_x_r;
  rrb_pkg::coord_t                        org_y_r;

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cos_r   <= rrb_pkg::FACTOR_ONE;
      sin_r   <= '0;
      org_x_r <= '0;
      org_y_r <= '0;
    end else if (cfg_valid) begin
      case (cfg_index)
        rrb_pkg::CFG_COS_FACTOR: cos_r   <= cfg_data[rrb_pkg::FACTOR_BITS-1:0];
        rrb_pkg::CFG_SIN_FACTOR: sin_r   <= cfg_data[rrb_pkg::FACTOR_BITS-1:0];
        rrb_pkg::CFG_ORIGIN_X:   org_x_r <= cfg_data[CB-1:0];
        rrb_pkg::CFG_ORIGIN_Y:   org_y_r <= cfg_data[CB-1:0];
        default: ;
      endcase
    end
  end

  // Stage valid bits and the ready chain that lets each stage fill while later ones stall.
  logic [4:0] vld_r;
  logic [4:0] rdy;

  assign rdy[4]     = !vld_r[4] || out_tready;
  assign rdy[3]     = !vld_r[3] || rdy[4];
  assign rdy[2]     = !vld_r[2] || rdy[3];
  assign rdy[1]     = !vld_r[1] || rdy[2];
  assign rdy[0]     = !vld_r[0] || rdy[1];
  assign in_tready  = rdy[0];
  assign out_tvalid = vld_r[4];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= '0;
    end else begin
      if (rdy[0]) vld_r[0] <= in_tvalid;
      if (rdy[1]) vld_r[1] <= vld_r[0];
      if (rdy[2]) vld_r[2] <= vld_r[1];
      if (rdy[3]) vld_r[3] <= vld_r[2];
      if (rdy[4]) vld_r[4] <= vld_r[3];
    end
  end

  logic [4:0] last_r;

  always_ff @(posedge clk) begin
    if (rdy[0]) last_r[0] <= in_tlast;
    if (rdy[1]) last_r[1] <= last_r[0];
    if (rdy[2]) last_r[2] <= last_r[1];
    if (rdy[3]) last_r[3] <= last_r[2];
    if (rdy[4]) last_r[4] <= last_r[3];
  end

  // Stage 1: corners relative to the origin.
  rrb_pkg::coord_t in_left, in_top, in_right, in_bottom;
  rrb_pkg::diff_t  dx0_nxt, dy0_nxt, dx1_nxt, dy1_nxt;
  rrb_pkg::diff_t  dx0_r, dy0_r, dx1_r, dy1_r;

  assign in_left   = in_tdata[0*CB +: CB];
  assign in_top    = in_tdata[1*CB +: CB];
  assign in_right  = in_tdata[2*CB +: CB];
  assign in_bottom = in_tdata[3*CB +: CB];

  assign dx0_nxt = rrb_pkg::DIFF_BITS'(in_left)   - rrb_pkg::DIFF_BITS'(org_x_r);
  assign dy0_nxt = rrb_pkg::DIFF_BITS'(in_top)    - rrb_pkg::DIFF_BITS'(org_y_r);
  assign dx1_nxt = rrb_pkg::DIFF_BITS'(in_right)  - rrb_pkg::DIFF_BITS'(org_x_r);
  assign dy1_nxt = rrb_pkg::DIFF_BITS'(in_bottom) - rrb_pkg::DIFF_BITS'(org_y_r);

  always_ff @(posedge clk) begin
    if (rdy[0]) begin
      dx0_r <= dx0_nxt;
      dy0_r <= dy0_nxt;
      dx1_r <= dx1_nxt;
      dy1_r <= dy1_nxt;
    end
  end

  // Stage 2: the eight distinct products that the four corners need.
  rrb_pkg::prod_t xc0_r, xc1_r, xs0_r, xs1_r, yc0_r, yc1_r, ys0_r, ys1_r;
  rrb_pkg::prod_t cos_w, sin_w;

  assign cos_w = rrb_pkg::PROD_BITS'(cos_r);
  assign sin_w = rrb_pkg::PROD_BITS'(sin_r);

  always_ff @(posedge clk) begin
    if (rdy[1]) begin
      xc0_r <= rrb_pkg::PROD_BITS'(dx0_r) * cos_w;
      xc1_r <= rrb_pkg::PROD_BITS'(dx1_r) * cos_w;
      xs0_r <= rrb_pkg::PROD_BITS'(dx0_r) * sin_w;
      xs1_r <= rrb_pkg::PROD_BITS'(dx1_r) * sin_w;
      yc0_r <= rrb_pkg::PROD_BITS'(dy0_r) * cos_w;
      yc1_r <= rrb_pkg::PROD_BITS'(dy1_r) * cos_w;
      ys0_r <= rrb_pkg::PROD_BITS'(dy0_r) * sin_w;
      ys1_r <= rrb_pkg::PROD_BITS'(dy1_r) * sin_w;
    end
  end

  // Stage 3: the x and y extremes separate, since x' = x*cos - y*sin and y' = x*sin + y*cos.
  rrb_pkg::prod_t min_xc_r, max_xc_r, min_ys_r, max_ys_r;
  rrb_pkg::prod_t min_xs_r, max_xs_r, min_yc_r, max_yc_r;

  always_ff @(posedge clk) begin
    if (rdy[2]) begin
      min_xc_r <= rrb_pkg::min_prod(xc0_r, xc1_r);
      max_xc_r <= rrb_pkg::max_prod(xc0_r, xc1_r);
      min_ys_r <= rrb_pkg::min_prod(ys0_r, ys1_r);
      max_ys_r <= rrb_pkg::max_prod(ys0_r, ys1_r);
      min_xs_r <= rrb_pkg::min_prod(xs0_r, xs1_r);
      max_xs_r <= rrb_pkg::max_prod(xs0_r, xs1_r);
      min_yc_r <= rrb_pkg::min_prod(yc0_r, yc1_r);
      max_yc_r <= rrb_pkg::max_prod(yc0_r, yc1_r);
    end
  end

  // Stage 4: bounds in fixed point with the origin added back; the maxima carry a ceiling bias.
  rrb_pkg::sum_t org_x_f, org_y_f;
  rrb_pkg::sum_t sum_l_r, sum_t_r, sum_r_r, sum_b_r;

  assign org_x_f = rrb_pkg::SUM_BITS'(org_x_r) <<< rrb_pkg::FRAC_BITS;
  assign org_y_f = rrb_pkg::SUM_BITS'(org_y_r) <<< rrb_pkg::FRAC_BITS;

  always_ff @(posedge clk) begin
    if (rdy[3]) begin
      sum_l_r <= rrb_pkg::SUM_BITS'(min_xc_r) - rrb_pkg::SUM_BITS'(max_ys_r) + org_x_f;
      sum_r_r <= rrb_pkg::SUM_BITS'(max_xc_r) - rrb_pkg::SUM_BITS'(min_ys_r) + org_x_f
                 + rrb_pkg::CEIL_BIAS;
      sum_t_r <= rrb_pkg::SUM_BITS'(min_xs_r) + rrb_pkg::SUM_BITS'(min_yc_r) + org_y_f;
      sum_b_r <= rrb_pkg::SUM_BITS'(max_xs_r) + rrb_pkg::SUM_BITS'(max_yc_r) + org_y_f
                 + rrb_pkg::CEIL_BIAS;
    end
  end

  // Stage 5: dropping the fraction bits floors; saturate into the coordinate range.
  rrb_pkg::coord_t bnd_l_r, bnd_t_r, bnd_r_r, bnd_b_r;

  always_ff @(posedge clk) begin
    if (rdy[4]) begin
      bnd_l_r <= rrb_pkg::sat_coord(sum_l_r[rrb_pkg::SUM_BITS-1:rrb_pkg::FRAC_BITS]);
      bnd_t_r <= rrb_pkg::sat_coord(sum_t_r[rrb_pkg::SUM_BITS-1:rrb_pkg::FRAC_BITS]);
      bnd_r_r <= rrb_pkg::sat_coord(sum_r_r[rrb_pkg::SUM_BITS-1:rrb_pkg::FRAC_BITS]);
      bnd_b_r <= rrb_pkg::sat_coord(sum_b_r[rrb_pkg::SUM_BITS-1:rrb_pkg::FRAC_BITS]);
    end
  end

  assign out_tdata = rrb_pkg::DATA_BITS'({bnd_b_r, bnd_r_r, bnd_t_r, bnd_l_r});
  assign out_tlast = last_r[4];

endmodule

@@ hw/rtl/rrb_checker.sv @@
// Port-level assertions for the rotated rectangle bounds block, bound to its top level.
`timescale 1ns / 1ps

module rrb_checker (
  input logic                          clk,
  input logic                          rst_n,
  input logic                          in_tready,
  input logic                          out_tvalid,
  input logic                          out_tready,
  input logic [rrb_pkg::DATA_BITS-1:0] out_tdata
);

  localparam int CB = rrb_pkg::COORD_BITS;

  rrb_pkg::coord_t b_left, b_top, b_right, b_bottom;

  assign b_left   = out_tdata[0*CB +: CB];
  assign b_top    = out_tdata[1*CB +: CB];
  assign b_right  = out_tdata[2*CB +: CB];
  assign b_bottom = out_tdata[3*CB +: CB];

  // A stalled result beat stays offered.
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !out_tready |=> out_tvalid)
    else $error("result beat withdrawn while stalled");

  // Reset empties the pipeline.
  a_reset_empty: assert property (@(posedge clk)
    !rst_n |=> !out_tvalid)
    else $error("result beat shown straight after reset");

  // With nothing waiting at the output, every stage can move, so input must be taken.
  a_ready_when_empty: assert property (@(posedge clk) disable iff (!rst_n)
    !out_tvalid |-> in_tready)
    else $error("input stalled with an empty output");

  // The floor of a minimum never exceeds the ceiling of the matching maximum.
  a_box_ordered: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid |-> (b_left <= b_right) && (b_top <= b_bottom))
    else $error("bounding box with minimum above maximum");

endmodule

bind rotated_rect_bounds_core rrb_checker u_rrb_checker (.*);
